### hdl/text_console_writer_unit_defines.svh
// ----------------------------------------------------------------------------
// text_console_writer_unit_defines.svh
// Assertion macros for the text console writer. Define ASSERT_OFF to drop them.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_UNIT_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
// Property that must hold at every clock edge outside reset
`define TCW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition in one cycle implies a condition in the next
`define TCW_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define TCW_ASSERT(lbl, prop, msg)
`define TCW_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

### hdl/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared codes, constants and control structs of the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

  // Request modes
  localparam logic [1:0] MODE_PUT   = 2'd0;
  localparam logic [1:0] MODE_CLEAR = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  // Control characters
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_RETURN  = 8'h0D;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  // Reset attribute and the blank cell that reset fills in
  localparam logic [7:0]  RESET_ATTR = 8'h07;
  localparam logic [15:0] RESET_CELL = {RESET_ATTR, CH_SPACE};

  // Port widths
  localparam int POS_W  = 11;
  localparam int CELL_W = 16;

  // Cursor unit status
  typedef struct packed {
    logic store;   // any byte but newline, return or tab: write it at the cursor
    logic scroll;  // cursor left the last row
  } cur_flags_t;

  // Address walker commands and status
  typedef struct packed {
    logic clear;
    logic step;
  } walk_cmd_t;

  typedef struct packed {
    logic at_zero;
    logic at_copy_end;
    logic at_end;
  } walk_stat_t;

endpackage

### hdl/tcw_ram.sv
// ----------------------------------------------------------------------------
// tcw_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hdl/tcw_cursor.sv
// ----------------------------------------------------------------------------
// tcw_cursor
// Next-cursor logic for one put byte: control characters, wrap and scroll.
// ----------------------------------------------------------------------------
module tcw_cursor import tcw_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic [$clog2(COLUMNS)-1:0] col,
  input  logic [$clog2(ROWS)-1:0]    row,
  input  logic [7:0]                 char_code,
  output logic [$clog2(COLUMNS)-1:0] col_nxt,
  output logic [$clog2(ROWS)-1:0]    row_nxt,
  output cur_flags_t                 flags
);

  localparam int CW = $clog2(COLUMNS);
  localparam int RW = $clog2(ROWS);
  localparam int CX = CW + 1;
  localparam int RX = RW + 1;

  logic [CX-1:0] col_x;
  logic [RX-1:0] row_x;

  always_comb begin
    col_x        = {1'b0, col};
    row_x        = {1'b0, row};
    flags.store  = 1'b0;
    // interpret the byte
    case (char_code)
      CH_NEWLINE: begin
        col_x = '0;
        row_x = row_x + 1'b1;
      end
      CH_RETURN: begin
        col_x = '0;
      end
      CH_TAB: begin
        col_x = (col_x + CX'(4)) & ~CX'(3);
      end
      default: begin
        flags.store = 1'b1;
        col_x       = col_x + 1'b1;
      end
    endcase
    // wrap past the last column
    if (col_x >= CX'(COLUMNS)) begin
      col_x = '0;
      row_x = row_x + 1'b1;
    end
    // past the last row: pin to it and scroll
    flags.scroll = (row_x >= RX'(ROWS));
    if (flags.scroll) begin
      row_x = RX'(ROWS - 1);
    end
  end

  assign col_nxt = col_x[CW-1:0];
  assign row_nxt = row_x[RW-1:0];

endmodule

### hdl/tcw_walk.sv
// ----------------------------------------------------------------------------
// tcw_walk
// Shared address walker for the clear, fill and scroll sweeps over the grid.
// ----------------------------------------------------------------------------
module tcw_walk import tcw_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  walk_cmd_t                     cmd,
  output logic [$clog2(ROWS*COLUMNS)-1:0] cnt,
  output logic [$clog2(ROWS*COLUMNS)-1:0] cnt_ofs,
  output walk_stat_t                    stat
);

  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW    = $clog2(CELLS);

  logic [AW-1:0] cnt_r;
  logic [AW-1:0] cnt_nxt;

  // Counter: clear has priority over step
  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.clear) begin
      cnt_nxt = '0;
    end else if (cmd.step) begin
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // Source address one row below, used by the scroll copy
  assign cnt            = cnt_r;
  assign cnt_ofs        = cnt_r + AW'(COLUMNS);
  assign stat.at_zero     = (cnt_r == '0);
  assign stat.at_copy_end = (cnt_r == AW'(CELLS - COLUMNS));
  assign stat.at_end      = (cnt_r == AW'(CELLS - 1));

endmodule

### hdl/text_console_writer_unit.sv
// ----------------------------------------------------------------------------
// text_console_writer_unit
// Text-mode console: a ROWS x COLUMNS grid of {attribute, character} cells and
// a cursor. A request is taken when start is high and busy is low. Mode put
// interprets one byte (newline, return, tab, else stored), clear blanks the grid
// and homes the cursor, read returns one cell. Each request gives one result
// on out_* for exactly one cycle, marked by out_strobe; the receiver cannot
// stall it. out_cursor_pos is the linear cursor position after the request.
// Put without scroll and unused modes give their result in the next cycle;
// read goes through ST_READ, clear through ST_FILL, put with scroll through
// ST_COPY then ST_FILL. The single write port of the cell RAM makes the
// copy and fills move one cell per cycle through the shared address walker.
// busy is high outside ST_IDLE; no request is taken during a sweep or a read.
// cfg_we/cfg_wdata set the attribute used by puts, clears and scroll fills.
// After reset a clearing pass fills all ROWS*COLUMNS cells (2000 by default)
// with spaces in attribute 7; busy is high meanwhile.
// ----------------------------------------------------------------------------
`include "text_console_writer_unit_defines.svh"

module text_console_writer_unit import tcw_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic              clk,
  input  logic              rst_n,
  // request channel
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        in_mode,
  input  logic [7:0]        in_char_code,
  input  logic [POS_W-1:0]  in_read_index,
  // result channel
  output logic              out_strobe,
  output logic [POS_W-1:0]  out_cursor_pos,
  output logic [CELL_W-1:0] out_cell_word,
  output logic              out_scrolled,
  // configuration
  input  logic              cfg_we,
  input  logic [7:0]        cfg_wdata
);

  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(COLUMNS);
  localparam int RW    = $clog2(ROWS);
  localparam int PW    = (AW > POS_W) ? AW : POS_W;

  typedef enum logic [4:0] {
    ST_INIT = 5'b00001,
    ST_IDLE = 5'b00010,
    ST_READ = 5'b00100,
    ST_COPY = 5'b01000,
    ST_FILL = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  logic [CW-1:0]     col_r, col_nxt;
  logic [RW-1:0]     row_r, row_nxt;
  logic [7:0]        attr_r;
  logic              out_strobe_r, out_strobe_nxt;
  logic [CELL_W-1:0] out_cell_word_r, out_cell_word_nxt;
  logic              out_scrolled_r, out_scrolled_nxt;
  logic              scroll_r, scroll_nxt;
  logic              rd_ok_r, rd_ok_nxt;
  logic [AW-1:0]     cp_wa_r;

  logic              accept;
  logic [AW-1:0]     cur_pos;
  logic [PW-1:0]     pos_ext;
  logic [PW-1:0]     rd_idx_ext;
  logic              rd_in_range;
  logic [CELL_W-1:0] blank;

  logic [CW-1:0]     cu_col;
  logic [RW-1:0]     cu_row;
  cur_flags_t        cu_flags;

  walk_cmd_t         walk_cmd;
  walk_stat_t        walk_stat;
  logic [AW-1:0]     walk_cnt;
  logic [AW-1:0]     walk_ofs;

  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [CELL_W-1:0] ram_wdata, ram_rdata;

  // Handshake and derived values
  assign accept      = start && (state_r == ST_IDLE);
  assign busy        = (state_r != ST_IDLE);
  assign cur_pos     = AW'(row_r * COLUMNS) + AW'(col_r);
  assign pos_ext     = PW'(cur_pos);
  assign rd_idx_ext  = PW'(in_read_index);
  assign rd_in_range = (32'(in_read_index) < CELLS);
  assign blank       = {attr_r, CH_SPACE};

  // Cursor unit
  tcw_cursor #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_cursor (
    .col       (col_r),
    .row       (row_r),
    .char_code (in_char_code),
    .col_nxt   (cu_col),
    .row_nxt   (cu_row),
    .flags     (cu_flags)
  );

  // Shared address walker
  tcw_walk #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_walk (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (walk_cmd),
    .cnt     (walk_cnt),
    .cnt_ofs (walk_ofs),
    .stat    (walk_stat)
  );

  // Cell memory
  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_cells (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Sequencer
  always_comb begin
    state_nxt         = state_r;
    col_nxt           = col_r;
    row_nxt           = row_r;
    out_strobe_nxt    = 1'b0;
    out_cell_word_nxt = out_cell_word_r;
    out_scrolled_nxt  = out_scrolled_r;
    scroll_nxt        = scroll_r;
    rd_ok_nxt         = rd_ok_r;
    walk_cmd          = '0;
    ram_we            = 1'b0;
    ram_waddr         = walk_cnt;
    ram_wdata         = blank;
    ram_re            = 1'b0;
    ram_raddr         = walk_ofs;
    unique case (state_r)
      ST_INIT: begin
        ram_we    = 1'b1;
        ram_wdata = RESET_CELL;
        if (walk_stat.at_end) begin
          state_nxt = ST_IDLE;
        end else begin
          walk_cmd.step = 1'b1;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          unique case (in_mode)
            MODE_PUT: begin
              col_nxt   = cu_col;
              row_nxt   = cu_row;
              ram_we    = cu_flags.store;
              ram_waddr = cur_pos;
              ram_wdata = {attr_r, in_char_code};
              if (cu_flags.scroll) begin
                scroll_nxt     = 1'b1;
                walk_cmd.clear = 1'b1;
                state_nxt      = ST_COPY;
              end else begin
                out_strobe_nxt    = 1'b1;
                out_cell_word_nxt = '0;
                out_scrolled_nxt  = 1'b0;
              end
            end
            MODE_CLEAR: begin
              col_nxt        = '0;
              row_nxt        = '0;
              scroll_nxt     = 1'b0;
              walk_cmd.clear = 1'b1;
              state_nxt      = ST_FILL;
            end
            MODE_READ: begin
              ram_re    = rd_in_range;
              ram_raddr = rd_idx_ext[AW-1:0];
              rd_ok_nxt = rd_in_range;
              state_nxt = ST_READ;
            end
            default: begin
              out_strobe_nxt    = 1'b1;
              out_cell_word_nxt = '0;
              out_scrolled_nxt  = 1'b0;
            end
          endcase
        end
      end
      ST_READ: begin
        out_strobe_nxt    = 1'b1;
        out_cell_word_nxt = rd_ok_r ? ram_rdata : '0;
        out_scrolled_nxt  = 1'b0;
        state_nxt         = ST_IDLE;
      end
      ST_COPY: begin
        // read one row below, write the cell read last cycle
        ram_re    = !walk_stat.at_copy_end;
        ram_raddr = walk_ofs;
        ram_we    = !walk_stat.at_zero;
        ram_waddr = cp_wa_r;
        ram_wdata = ram_rdata;
        if (walk_stat.at_copy_end) begin
          state_nxt = ST_FILL;
        end else begin
          walk_cmd.step = 1'b1;
        end
      end
      ST_FILL: begin
        ram_we = 1'b1;
        if (walk_stat.at_end) begin
          out_strobe_nxt    = 1'b1;
          out_cell_word_nxt = '0;
          out_scrolled_nxt  = scroll_r;
          state_nxt         = ST_IDLE;
        end else begin
          walk_cmd.step = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_INIT;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_INIT;
      col_r        <= '0;
      row_r        <= '0;
      attr_r       <= RESET_ATTR;
      out_strobe_r <= 1'b0;
      scroll_r     <= 1'b0;
      rd_ok_r      <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      col_r        <= col_nxt;
      row_r        <= row_nxt;
      out_strobe_r <= out_strobe_nxt;
      scroll_r     <= scroll_nxt;
      rd_ok_r      <= rd_ok_nxt;
      if (cfg_we) begin
        attr_r <= cfg_wdata;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    out_cell_word_r <= out_cell_word_nxt;
    out_scrolled_r  <= out_scrolled_nxt;
    cp_wa_r         <= walk_cnt;
  end

  // Result ports
  assign out_strobe     = out_strobe_r;
  assign out_cursor_pos = pos_ext[POS_W-1:0];
  assign out_cell_word  = out_cell_word_r;
  assign out_scrolled   = out_scrolled_r;

  // Checks
  `TCW_ASSERT(a_strobe_idle, out_strobe_r |-> (state_r == ST_IDLE), "result outside idle")
  `TCW_ASSERT(a_cursor_range, (32'(row_r) < ROWS) && (32'(col_r) < COLUMNS), "cursor off grid")
  `TCW_ASSERT_NEXT(a_read_next, accept && (in_mode == MODE_READ), state_r == ST_READ, "read lost")
  `TCW_ASSERT_NEXT(a_copy_fill, (state_r == ST_COPY) && walk_stat.at_copy_end, (state_r == ST_FILL) && walk_stat.at_copy_end, "scroll fill start wrong")

endmodule
